// ----- rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, command codes, word types and ring index helper for the
// double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_SEARCH     = 3'd4;
    localparam logic [2:0] CMD_CLEAR      = 3'd5;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] key;
    } t_cmd_word;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] popped_key;
        logic [3:0]         found_index;
        logic [4:0]         entry_count;
        logic signed [31:0] front_key;
        logic signed [31:0] back_key;
    } t_res_word;

    // ring position of ptr + off, with off below DEPTH
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(ptr) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(DEPTH)) begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

// ----- rtl/deq_ram.sv -----
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/double_ended_queue_core.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of 32-bit signed keys kept as a ring in a RAM.
// ----------------------------------------------------------------------------
// One command word in, one result word out. Pushes, clear, unused codes and
// any refused command finish in the cycle of acceptance. A pop that leaves
// the queue non-empty passes through a read state, because the new end key
// is fetched through the RAM's single registered read port. A search scans
// from the front to the first match or the last entry, ending at acceptance
// when empty. The RAM read port scans one entry per cycle. The input is not
// ready while a pop or search is in progress; the result waits in an output
// register, and the next command is taken in the cycle that result leaves.
module double_ended_queue_core
    import deq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_cmd_word i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_res_word o_out_word
);

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_RD_FRONT = 2'd1;
    localparam logic [1:0] S_RD_BACK  = 2'd2;
    localparam logic [1:0] S_SEARCH   = 2'd3;

    logic [1:0]         r_state,     n_state;
    logic [PTR_W-1:0]   r_fp,        n_fp;
    logic [CNT_W-1:0]   r_count,     n_count;
    logic signed [31:0] r_front,     n_front;
    logic signed [31:0] r_back,      n_back;
    logic signed [31:0] r_key,       n_key;
    logic signed [31:0] r_popped,    n_popped;
    logic [PTR_W-1:0]   r_idx,       n_idx;
    t_res_word          r_out,       n_out;
    logic               r_out_valid, n_out_valid;

    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    logic [31:0]        ram_wdata;
    logic [PTR_W-1:0]   ram_raddr;
    logic [31:0]        ram_rdata;

    logic               in_acc;
    logic               empty;
    logic               full;
    logic [PTR_W-1:0]   fp_inc;
    logic [PTR_W-1:0]   fp_dec;
    logic               done;
    logic               res_ok;
    logic signed [31:0] res_popped;
    logic [PTR_W-1:0]   res_found;
    logic [31:0]        found_ext;
    logic [31:0]        count_ext;

    deq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_key_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign empty  = (r_count == '0);
    assign full   = (r_count == CNT_W'(DEPTH));
    assign fp_inc = (r_fp == PTR_W'(DEPTH - 1)) ? '0 : r_fp + 1'b1;
    assign fp_dec = (r_fp == '0) ? PTR_W'(DEPTH - 1) : r_fp - 1'b1;

    always_comb begin
        n_state     = r_state;
        n_fp        = r_fp;
        n_count     = r_count;
        n_front     = r_front;
        n_back      = r_back;
        n_key       = r_key;
        n_popped    = r_popped;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_waddr   = r_fp;
        ram_wdata   = i_in_word.key;
        ram_raddr   = r_fp;
        done        = 1'b0;
        res_ok      = 1'b0;
        res_popped  = '0;
        res_found   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_word.command)
                        CMD_PUSH_FRONT: begin
                            done = 1'b1;
                            if (!full) begin
                                res_ok    = 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = fp_dec;
                                n_fp      = fp_dec;
                                n_count   = r_count + 1'b1;
                                n_front   = i_in_word.key;
                                if (empty) begin
                                    n_back = i_in_word.key;
                                end
                            end
                        end
                        CMD_PUSH_BACK: begin
                            done = 1'b1;
                            if (!full) begin
                                res_ok    = 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = ring_add(r_fp, r_count);
                                n_count   = r_count + 1'b1;
                                n_back    = i_in_word.key;
                                if (empty) begin
                                    n_front = i_in_word.key;
                                end
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) begin
                                done = 1'b1;
                            end else begin
                                n_popped = r_front;
                                n_fp     = fp_inc;
                                n_count  = r_count - 1'b1;
                                if (r_count == CNT_W'(1)) begin
                                    done       = 1'b1;
                                    res_ok     = 1'b1;
                                    res_popped = r_front;
                                end else begin
                                    ram_raddr = fp_inc;
                                    n_state   = S_RD_FRONT;
                                end
                            end
                        end
                        CMD_POP_BACK: begin
                            if (empty) begin
                                done = 1'b1;
                            end else begin
                                n_popped = r_back;
                                n_count  = r_count - 1'b1;
                                if (r_count == CNT_W'(1)) begin
                                    done       = 1'b1;
                                    res_ok     = 1'b1;
                                    res_popped = r_back;
                                end else begin
                                    ram_raddr = ring_add(r_fp, r_count - CNT_W'(2));
                                    n_state   = S_RD_BACK;
                                end
                            end
                        end
                        CMD_SEARCH: begin
                            n_key = i_in_word.key;
                            if (empty) begin
                                done = 1'b1;
                            end else begin
                                ram_raddr = r_fp;
                                n_idx     = '0;
                                n_state   = S_SEARCH;
                            end
                        end
                        CMD_CLEAR: begin
                            done    = 1'b1;
                            res_ok  = 1'b1;
                            n_fp    = '0;
                            n_count = '0;
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_RD_FRONT: begin
                n_front    = ram_rdata;
                done       = 1'b1;
                res_ok     = 1'b1;
                res_popped = r_popped;
                n_state    = S_IDLE;
            end
            S_RD_BACK: begin
                n_back     = ram_rdata;
                done       = 1'b1;
                res_ok     = 1'b1;
                res_popped = r_popped;
                n_state    = S_IDLE;
            end
            S_SEARCH: begin
                if (ram_rdata == r_key) begin
                    done      = 1'b1;
                    res_ok    = 1'b1;
                    res_found = r_idx;
                    n_state   = S_IDLE;
                end else if (CNT_W'(r_idx) == r_count - CNT_W'(1)) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ram_raddr = ring_add(r_fp, CNT_W'(r_idx) + CNT_W'(1));
                    n_idx     = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        found_ext = 32'(res_found);
        count_ext = 32'(n_count);
        if (done) begin
            n_out_valid       = 1'b1;
            n_out.ok          = res_ok;
            n_out.popped_key  = res_popped;
            n_out.found_index = found_ext[3:0];
            n_out.entry_count = count_ext[4:0];
            n_out.front_key   = (n_count == '0) ? '0 : n_front;
            n_out.back_key    = (n_count == '0) ? '0 : n_back;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fp        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fp        <= n_fp;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_front  <= n_front;
        r_back   <= n_back;
        r_key    <= n_key;
        r_popped <= n_popped;
        r_idx    <= n_idx;
        r_out    <= n_out;
    end

endmodule

// ----- tb/tb_double_ended_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_core
// Self-checking bench for the double-ended queue. A driver feeds command
// words from a backlog, a monitor takes result words with random stalls, and
// a shadow deque predicts every result. Directed corner cases come first,
// then random phases biased toward growing, shrinking, filling and scanning.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_core;
    import deq_pkg::*;

    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;
    localparam int HOLD_CYCLES = 80;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_ready;
    t_cmd_word in_word = '0;
    logic      o_out_valid;
    logic      out_ready = 1'b0;
    t_res_word o_out_word;

    t_cmd_word         cmd_backlog[$];
    t_res_word         pending_results[$];
    logic signed [31:0] pushed_keys[$];

    logic signed [31:0] shadow_keys[DEPTH];
    int shadow_front = 0;
    int shadow_fill = 0;

    int errors = 0;
    int total_words = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_reqs = 0;
    int hold_done = 0;
    bit calm = 1'b0;

    double_ended_queue_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic int ring_pos(input int off);
        return (shadow_front + off) % DEPTH;
    endfunction

    function automatic t_res_word deque_apply(input t_cmd_word w);
        t_res_word r;
        bit hit;
        r = '0;
        hit = 1'b0;
        case (w.command)
            CMD_PUSH_FRONT: begin
                if (shadow_fill < DEPTH) begin
                    shadow_front = ring_pos(DEPTH - 1);
                    shadow_keys[shadow_front] = w.key;
                    shadow_fill++;
                    r.ok = 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (shadow_fill < DEPTH) begin
                    shadow_keys[ring_pos(shadow_fill)] = w.key;
                    shadow_fill++;
                    r.ok = 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (shadow_fill > 0) begin
                    r.popped_key = shadow_keys[shadow_front];
                    shadow_front = ring_pos(1);
                    shadow_fill--;
                    r.ok = 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (shadow_fill > 0) begin
                    r.popped_key = shadow_keys[ring_pos(shadow_fill - 1)];
                    shadow_fill--;
                    r.ok = 1'b1;
                end
            end
            CMD_SEARCH: begin
                for (int i = 0; i < shadow_fill; i++) begin
                    if (!hit && shadow_keys[ring_pos(i)] == w.key) begin
                        hit = 1'b1;
                        r.ok = 1'b1;
                        r.found_index = i[3:0];
                    end
                end
            end
            CMD_CLEAR: begin
                shadow_front = 0;
                shadow_fill = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.entry_count = shadow_fill[4:0];
        if (shadow_fill > 0) begin
            r.front_key = shadow_keys[shadow_front];
            r.back_key = shadow_keys[ring_pos(shadow_fill - 1)];
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (errors < 50) begin
            $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
        end
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                pending_results.push_back(deque_apply(in_word));
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (cmd_backlog.size() > 0 && !calm && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(0, 9);
                    in_valid <= 1'b0;
                end else if (cmd_backlog.size() > 0) begin
                    in_valid <= 1'b1;
                    in_word <= cmd_backlog.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res_word want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected word", '0, 32'(o_out_word.entry_count));
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_word.ok !== want.ok)
                        flag_mismatch("ok", 32'(want.ok), 32'(o_out_word.ok));
                    if (o_out_word.popped_key !== want.popped_key)
                        flag_mismatch("popped_key", want.popped_key, o_out_word.popped_key);
                    if (o_out_word.found_index !== want.found_index)
                        flag_mismatch("found_index", 32'(want.found_index),
                                      32'(o_out_word.found_index));
                    if (o_out_word.entry_count !== want.entry_count)
                        flag_mismatch("entry_count", 32'(want.entry_count),
                                      32'(o_out_word.entry_count));
                    if (o_out_word.front_key !== want.front_key)
                        flag_mismatch("front_key", want.front_key, o_out_word.front_key);
                    if (o_out_word.back_key !== want.back_key)
                        flag_mismatch("back_key", want.back_key, o_out_word.back_key);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (hold_done < hold_reqs) begin
                hold_done++;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 9);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [31:0] rand_key();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            return $urandom_range(0, 7);
        end else if (pick == 4) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7fff_ffff;
                1: return 32'sh8000_0000;
                2: return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic signed [31:0] search_key();
        if (pushed_keys.size() > 0 && $urandom_range(0, 2) == 0) begin
            return pushed_keys[$urandom_range(0, pushed_keys.size() - 1)];
        end
        return rand_key();
    endfunction

    task automatic queue_word(input logic [2:0] cmd, input logic signed [31:0] key);
        t_cmd_word w;
        w.command = cmd;
        w.key = key;
        cmd_backlog.push_back(w);
        total_words++;
        if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) begin
            pushed_keys.push_back(key);
            if (pushed_keys.size() > 32) begin
                void'(pushed_keys.pop_front());
            end
        end
    endtask

    task automatic drain();
        while (cmd_backlog.size() != 0 || in_valid || pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int phase_no;
        int kind;
        int n;
        int r;
        int push_lim;
        int pop_lim;
        logic signed [31:0] base;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue corners, extremes, unused codes, clear
        queue_word(CMD_POP_FRONT, 32'sd0);
        queue_word(CMD_POP_BACK, -32'sd1);
        queue_word(CMD_SEARCH, 32'sd0);
        queue_word(CMD_SPARE_A, 32'sh7fff_ffff);
        queue_word(CMD_SPARE_B, 32'sh8000_0000);
        queue_word(CMD_PUSH_FRONT, 32'sh7fff_ffff);
        queue_word(CMD_PUSH_BACK, 32'sh8000_0000);
        queue_word(CMD_PUSH_FRONT, -32'sd1);
        queue_word(CMD_SEARCH, 32'sh8000_0000);
        queue_word(CMD_SEARCH, 32'sh7fff_ffff);
        queue_word(CMD_SEARCH, 32'sd12345);
        queue_word(CMD_SPARE_B, 32'sd0);
        queue_word(CMD_POP_BACK, 32'sd0);
        queue_word(CMD_POP_FRONT, 32'sd0);
        queue_word(CMD_POP_FRONT, 32'sd0);
        queue_word(CMD_PUSH_BACK, 32'sd5);
        queue_word(CMD_CLEAR, -32'sd1);
        queue_word(CMD_POP_BACK, 32'sd0);
        drain();

        phase_no = 0;
        while (total_words < 2000) begin
            if (total_words > 1750) calm = 1'b1;
            if (phase_no == 3 || phase_no == 9) hold_reqs++;
            kind = (phase_no == 0) ? 3 : $urandom_range(0, 3);
            if (kind == 3) begin
                // fill to the brim, try both pushes when full, then scan
                base = $urandom;
                queue_word(CMD_CLEAR, $urandom);
                for (int i = 0; i < DEPTH; i++) begin
                    queue_word($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                               base + i);
                end
                queue_word(CMD_PUSH_FRONT, rand_key());
                queue_word(CMD_PUSH_BACK, rand_key());
                for (int i = 0; i < DEPTH; i++) begin
                    queue_word(CMD_SEARCH, base + $urandom_range(0, DEPTH - 1));
                end
                queue_word(CMD_SEARCH, base + DEPTH);
            end else begin
                push_lim = (kind == 0) ? 120 : (kind == 1) ? 40 : 80;
                pop_lim = push_lim + ((kind == 0) ? 30 : (kind == 1) ? 110 : 70);
                n = $urandom_range(40, 120);
                for (int i = 0; i < n; i++) begin
                    r = $urandom_range(0, 199);
                    if (r < push_lim)
                        queue_word($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                                   rand_key());
                    else if (r < pop_lim)
                        queue_word($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK,
                                   $urandom);
                    else if (r < 197)
                        queue_word(CMD_SEARCH, search_key());
                    else if (r < 198)
                        queue_word(CMD_CLEAR, $urandom);
                    else
                        queue_word((r == 198) ? CMD_SPARE_A : CMD_SPARE_B, $urandom);
                end
            end
            drain();
            phase_no++;
        end

        repeat (40) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            flag_mismatch("words never seen", '0, pending_results.size());
        end
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- double_ended_queue_core.f -----
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/double_ended_queue_core.sv
tb/tb_double_ended_queue_core.sv
